@@ design/bstf_pkg.sv @@
// Shared types, codes and helpers of the letterbox image scaler.
`timescale 1ns / 1ps

package bstf_pkg;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] OP_BEGIN_ROW = 2'd0;
    localparam logic [1:0] OP_LOAD_PIX  = 2'd1;
    localparam logic [1:0] OP_EMIT_PIX  = 2'd2;
    localparam logic [1:0] OP_ROW_FAIL  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_ROWS_TOP_DOWN = 3'd2;
    localparam logic [2:0] CFG_PIXEL_OFFSET  = 3'd3;
    localparam logic [2:0] CFG_BACKGROUND    = 3'd4;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_GEO_INIT = 11'b000_0000_0010,
        S_GEO_X    = 11'b000_0000_0100,
        S_GEO_Y    = 11'b000_0000_1000,
        S_GEO_MUL  = 11'b000_0001_0000,
        S_GEO_DIM  = 11'b000_0010_0000,
        S_ROW_DIV  = 11'b000_0100_0000,
        S_ROW_MUL  = 11'b000_1000_0000,
        S_PIX_DIV  = 11'b001_0000_0000,
        S_PIX_RD   = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } t_state;

    // Packs a stored {red, green, blue} entry into RGB565.
    function automatic logic [15:0] to_rgb565(input logic [23:0] rgb);
        return {rgb[23:19], rgb[15:10], rgb[7:3]};
    endfunction

endpackage

@@ design/bstf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bstf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bmp_scale_to_fit_letterbox.sv @@
// Letterbox scaler: load and row-failed words are handled in the idle state; begin-row and emit
// words may need the shared bit-serial divider (one quotient bit a cycle).
// One word is processed at a time; a finished result waits in the output register
// while the next word is taken. After reset and after every configuration write the
// geometry is recomputed with two divisions, with input held off.
// Reset is synchronous, active low; the line store is not cleared.
`timescale 1ns / 1ps

module bmp_scale_to_fit_letterbox #(
    parameter int PANEL_WIDTH      = 800,
    parameter int PANEL_HEIGHT     = 480,
    parameter int MAX_SOURCE_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // dest_row[8:0], source_column[20:9], dest_column[30:21], blue[38:31],
    // green[46:39], red[54:47], zero pad[55]
    input  logic [55:0] i_s_tdata,
    // operation[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // fetch_offset[29:0], fetch_bytes[43:30], pixel_color[59:44],
    // pixel_address[78:60], zero pad[79]
    output logic [79:0] o_m_tdata,
    // fetch_needed[0]
    output logic [0:0]  o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data
);

    localparam int PMAX  = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int NUMW  = $clog2(PMAX * 256 + 1);
    localparam int MW    = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int AW    = $clog2(MAX_SOURCE_WIDTH);
    localparam int DIVA  = (NUMW > 16) ? NUMW : 16;
    localparam int DIVW  = (DIVA > MW) ? DIVA : MW;
    localparam int CW    = $clog2(DIVW + 1);
    localparam int WW    = $clog2(PANEL_WIDTH + 1);
    localparam int HW    = $clog2(PANEL_HEIGHT + 1);
    localparam int SW    = MW + 2;

    // Configuration registers.
    logic [12:0] r_src_w;
    logic [15:0] r_src_h;
    logic        r_top_first;
    logic [21:0] r_pdo;
    logic [15:0] r_bg;

    // Geometry.
    logic [DIVW-1:0]    r_sx, n_sx;
    logic [DIVW-1:0]    r_scale, n_scale;
    logic [MW+DIVW-1:0] r_pw_prod, n_pw_prod;
    logic [16+DIVW-1:0] r_ph_prod, n_ph_prod;
    logic [WW-1:0]      r_iw, n_iw, r_left, n_left;
    logic [HW-1:0]      r_ih, n_ih, r_top, n_top;

    // Row state.
    logic [8:0] r_cur_row, n_cur_row;
    logic       r_active, n_active;
    logic       r_failed, n_failed;
    logic [15:0] r_frow, n_frow;

    // Divider.
    logic [DIVW-1:0] r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [DIVW:0]   w_rem_sh, w_diff;

    // Pending result and output register.
    logic        r_res_need, n_res_need;
    logic [29:0] r_res_off, n_res_off;
    logic [13:0] r_res_bytes, n_res_bytes;
    logic [15:0] r_res_color, n_res_color;
    logic [18:0] r_res_addr, n_res_addr;
    logic        r_ov, n_ov;
    logic [79:0] r_o_data, n_o_data;
    logic        r_o_need, n_o_need;

    bstf_pkg::t_state r_state, n_state;

    logic [MW-1:0]  w_ew;
    logic [15:0]    w_eh;
    logic [SW-1:0]  w_stride;
    logic           w_in_acc, w_cfg_acc;
    logic [1:0]     w_op;
    logic [8:0]     w_drow;
    logic [11:0]    w_scol;
    logic [9:0]     w_dcol;
    logic [23:0]    w_rgb;
    logic           w_we;
    logic [AW-1:0]  w_raddr;
    logic [23:0]    w_rdata;
    logic [MW+DIVW-1:0] w_dw_raw;
    logic [16+DIVW-1:0] w_dh_raw;
    logic [31:0]    w_addr_full, w_off_full, w_tmp;
    logic [DIVW-1:0] w_sy;

    assign w_ew = (r_src_w == 13'd0) ? MW'(1) :
                  (32'(r_src_w) > MAX_SOURCE_WIDTH) ? MW'(MAX_SOURCE_WIDTH) : MW'(r_src_w);
    assign w_eh = (r_src_h == 16'd0) ? 16'd1 : r_src_h;
    assign w_stride = (SW'(w_ew) * SW'(3) + SW'(3)) & ~SW'(3);

    assign o_cfg_ready = (r_state == bstf_pkg::S_IDLE);
    assign o_s_tready  = (r_state == bstf_pkg::S_IDLE) && !i_cfg_valid;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_s_tvalid && o_s_tready;

    assign w_op   = i_s_tuser;
    assign w_drow = i_s_tdata[8:0];
    assign w_scol = i_s_tdata[20:9];
    assign w_dcol = i_s_tdata[30:21];
    assign w_rgb  = {i_s_tdata[54:47], i_s_tdata[46:39], i_s_tdata[38:31]};

    assign w_we = w_in_acc && (w_op == bstf_pkg::OP_LOAD_PIX) &&
                  (32'(w_scol) < MAX_SOURCE_WIDTH);
    assign w_raddr = r_quo[AW-1:0];

    bstf_ram #(
        .WIDTH(24),
        .DEPTH(MAX_SOURCE_WIDTH)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AW'(w_scol)),
        .i_wdata(w_rgb),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // One restoring division step.
    assign w_rem_sh = {r_rem, r_quo[DIVW-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    assign w_dw_raw = r_pw_prod >> 8;
    assign w_dh_raw = r_ph_prod >> 8;

    always_comb begin
        n_state     = r_state;
        n_sx        = r_sx;
        n_scale     = r_scale;
        n_pw_prod   = r_pw_prod;
        n_ph_prod   = r_ph_prod;
        n_iw        = r_iw;
        n_ih        = r_ih;
        n_left      = r_left;
        n_top       = r_top;
        n_cur_row   = r_cur_row;
        n_active    = r_active;
        n_failed    = r_failed;
        n_frow      = r_frow;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_res_need  = r_res_need;
        n_res_off   = r_res_off;
        n_res_bytes = r_res_bytes;
        n_res_color = r_res_color;
        n_res_addr  = r_res_addr;
        n_ov        = r_ov;
        n_o_data    = r_o_data;
        n_o_need    = r_o_need;
        w_addr_full = 32'(r_cur_row) * 32'(PANEL_WIDTH) + 32'(w_dcol);
        w_off_full  = 32'(r_pdo) + 32'(r_frow) * 32'(w_stride);
        w_tmp       = 32'd0;
        w_sy        = r_quo;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        // Divider runs in every division state until its count is spent.
        if (r_cnt != '0) begin
            n_cnt = r_cnt - CW'(1);
            if (!w_diff[DIVW]) begin
                n_rem = w_diff[DIVW-1:0];
                n_quo = {r_quo[DIVW-2:0], 1'b1};
            end else begin
                n_rem = w_rem_sh[DIVW-1:0];
                n_quo = {r_quo[DIVW-2:0], 1'b0};
            end
        end

        unique case (r_state)
            bstf_pkg::S_IDLE: begin
                if (w_cfg_acc) begin
                    n_state = bstf_pkg::S_GEO_INIT;
                end else if (w_in_acc) begin
                    n_res_need  = 1'b0;
                    n_res_off   = 30'd0;
                    n_res_bytes = 14'd0;
                    n_res_color = 16'd0;
                    n_res_addr  = 19'd0;
                    unique case (w_op)
                        bstf_pkg::OP_BEGIN_ROW: begin
                            n_cur_row = w_drow;
                            n_failed  = 1'b0;
                            n_active  = (32'(w_drow) >= 32'(r_top)) &&
                                        (32'(w_drow) < 32'(r_top) + 32'(r_ih));
                            if (n_active) begin
                                w_tmp   = (32'(w_drow) - 32'(r_top)) << 8;
                                n_quo   = DIVW'(w_tmp);
                                n_rem   = '0;
                                n_dvs   = r_scale;
                                n_cnt   = CW'(DIVW);
                                n_state = bstf_pkg::S_ROW_DIV;
                            end else begin
                                n_state = bstf_pkg::S_OUT;
                            end
                        end
                        bstf_pkg::OP_ROW_FAIL: begin
                            n_failed = 1'b1;
                        end
                        bstf_pkg::OP_EMIT_PIX: begin
                            if ((32'(r_cur_row) < PANEL_HEIGHT) &&
                                (32'(w_dcol) < PANEL_WIDTH)) begin
                                n_res_addr  = w_addr_full[18:0];
                                n_res_color = r_bg;
                                if (r_active && !r_failed &&
                                    (32'(w_dcol) >= 32'(r_left)) &&
                                    (32'(w_dcol) < 32'(r_left) + 32'(r_iw))) begin
                                    w_tmp   = (32'(w_dcol) - 32'(r_left)) << 8;
                                    n_quo   = DIVW'(w_tmp);
                                    n_rem   = '0;
                                    n_dvs   = r_scale;
                                    n_cnt   = CW'(DIVW);
                                    n_state = bstf_pkg::S_PIX_DIV;
                                end else begin
                                    n_state = bstf_pkg::S_OUT;
                                end
                            end
                        end
                        default: begin
                            // Pixel loads are written straight into the line store.
                        end
                    endcase
                end
            end
            bstf_pkg::S_GEO_INIT: begin
                n_quo   = DIVW'(PANEL_WIDTH * 256);
                n_rem   = '0;
                n_dvs   = DIVW'(w_ew);
                n_cnt   = CW'(DIVW);
                n_state = bstf_pkg::S_GEO_X;
            end
            bstf_pkg::S_GEO_X: begin
                if (r_cnt == '0) begin
                    n_sx    = r_quo;
                    n_quo   = DIVW'(PANEL_HEIGHT * 256);
                    n_rem   = '0;
                    n_dvs   = DIVW'(w_eh);
                    n_cnt   = CW'(DIVW);
                    n_state = bstf_pkg::S_GEO_Y;
                end
            end
            bstf_pkg::S_GEO_Y: begin
                if (r_cnt == '0) begin
                    n_scale = (r_sx < r_quo) ? r_sx : r_quo;
                    if (n_scale == '0) begin
                        n_scale = DIVW'(1);
                    end
                    n_state = bstf_pkg::S_GEO_MUL;
                end
            end
            bstf_pkg::S_GEO_MUL: begin
                n_pw_prod = (MW+DIVW)'(w_ew) * (MW+DIVW)'(r_scale);
                n_ph_prod = (16+DIVW)'(w_eh) * (16+DIVW)'(r_scale);
                n_state   = bstf_pkg::S_GEO_DIM;
            end
            bstf_pkg::S_GEO_DIM: begin
                if (w_dw_raw > (MW+DIVW)'(PANEL_WIDTH)) begin
                    n_iw = WW'(PANEL_WIDTH);
                end else if (w_dw_raw == '0) begin
                    n_iw = WW'(1);
                end else begin
                    n_iw = WW'(w_dw_raw);
                end
                if (w_dh_raw > (16+DIVW)'(PANEL_HEIGHT)) begin
                    n_ih = HW'(PANEL_HEIGHT);
                end else if (w_dh_raw == '0) begin
                    n_ih = HW'(1);
                end else begin
                    n_ih = HW'(w_dh_raw);
                end
                n_left  = (WW'(PANEL_WIDTH) - n_iw) >> 1;
                n_top   = (HW'(PANEL_HEIGHT) - n_ih) >> 1;
                n_state = bstf_pkg::S_IDLE;
            end
            bstf_pkg::S_ROW_DIV: begin
                if (r_cnt == '0) begin
                    if (r_quo >= DIVW'(w_eh)) begin
                        w_sy = DIVW'(w_eh - 16'd1);
                    end
                    n_frow  = r_top_first ? w_sy[15:0] : (w_eh - 16'd1 - w_sy[15:0]);
                    n_state = bstf_pkg::S_ROW_MUL;
                end
            end
            bstf_pkg::S_ROW_MUL: begin
                n_res_need  = 1'b1;
                n_res_off   = w_off_full[29:0];
                n_res_bytes = w_stride[13:0];
                n_state     = bstf_pkg::S_OUT;
            end
            bstf_pkg::S_PIX_DIV: begin
                if (r_cnt == '0) begin
                    // Beyond the line store the background stays in place.
                    if (r_quo < DIVW'(MAX_SOURCE_WIDTH)) begin
                        n_state = bstf_pkg::S_PIX_RD;
                    end else begin
                        n_state = bstf_pkg::S_OUT;
                    end
                end
            end
            bstf_pkg::S_PIX_RD: begin
                n_res_color = bstf_pkg::to_rgb565(w_rdata);
                n_state     = bstf_pkg::S_OUT;
            end
            bstf_pkg::S_OUT: begin
                if (!r_ov || i_m_tready) begin
                    n_ov     = 1'b1;
                    n_o_need = r_res_need;
                    n_o_data = {1'b0, r_res_addr, r_res_color, r_res_bytes, r_res_off};
                    n_state  = bstf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bstf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bstf_pkg::S_GEO_INIT;
            r_src_w     <= 13'd1;
            r_src_h     <= 16'd1;
            r_top_first <= 1'b0;
            r_pdo       <= 22'd54;
            r_bg        <= 16'd0;
            r_cur_row   <= 9'd0;
            r_active    <= 1'b0;
            r_failed    <= 1'b0;
            r_cnt       <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_row <= n_cur_row;
            r_active  <= n_active;
            r_failed  <= n_failed;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    bstf_pkg::CFG_SOURCE_WIDTH:  r_src_w     <= i_cfg_data[12:0];
                    bstf_pkg::CFG_SOURCE_HEIGHT: r_src_h     <= i_cfg_data[15:0];
                    bstf_pkg::CFG_ROWS_TOP_DOWN: r_top_first <= i_cfg_data[0];
                    bstf_pkg::CFG_PIXEL_OFFSET:  r_pdo       <= i_cfg_data;
                    bstf_pkg::CFG_BACKGROUND:    r_bg        <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx        <= n_sx;
        r_scale     <= n_scale;
        r_pw_prod   <= n_pw_prod;
        r_ph_prod   <= n_ph_prod;
        r_iw        <= n_iw;
        r_ih        <= n_ih;
        r_left      <= n_left;
        r_top       <= n_top;
        r_frow      <= n_frow;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_dvs       <= n_dvs;
        r_res_need  <= n_res_need;
        r_res_off   <= n_res_off;
        r_res_bytes <= n_res_bytes;
        r_res_color <= n_res_color;
        r_res_addr  <= n_res_addr;
        r_o_data    <= n_o_data;
        r_o_need    <= n_o_need;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_need;

endmodule
